FILE: src/decimal_radix_sorter_defines.svh
// Assertion macros for the decimal radix sorter.
// Depends on nothing; expects clk and rst in the scope of each use.
`ifndef DECIMAL_RADIX_SORTER_DEFINES_SVH
`define DECIMAL_RADIX_SORTER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define DRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drs check failed");

// Next-cycle implication, disabled in reset
`define DRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drs check failed");

`endif

FILE: src/drs_pkg.sv
// Shared types and constants for the decimal radix sorter.
// Depends on nothing.
package drs_pkg;

  localparam int KEY_W   = 20;
  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int RADIX   = 10;
  localparam int DIGIT_W = $clog2(RADIX);

  // Reciprocal of ten, exact for every key of KEY_W bits
  localparam int DIV_SHIFT = KEY_W + 4;
  localparam longint unsigned DIV_RECIP_L = (64'd1 << DIV_SHIFT) / RADIX + 1;
  localparam logic [KEY_W:0] DIV_RECIP = (KEY_W + 1)'(DIV_RECIP_L);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last_in;
  } in_beat_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic             last_out;
    logic             overflow;
  } out_beat_t;

  // Stored key with its running quotient by the current decimal place
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] quot;
  } entry_t;

  typedef struct packed {
    logic               clear;
    logic               inc;
    logic               prefix;
    logic               dec;
    logic [DIGIT_W-1:0] digit;
    logic [DIGIT_W-1:0] pidx;
  } hist_ctrl_t;

endpackage

FILE: src/drs_div10.sv
// Shared divide-by-ten unit: quotient by reciprocal multiply, digit as remainder.
// Depends on drs_pkg.
module drs_div10 (
  input  logic [drs_pkg::KEY_W-1:0]   x,
  output logic [drs_pkg::KEY_W-1:0]   q,
  output logic [drs_pkg::DIGIT_W-1:0] digit
);

  logic [2*drs_pkg::KEY_W:0]   prod;
  logic [drs_pkg::KEY_W+2:0]   tenq_wide;
  logic [drs_pkg::KEY_W-1:0]   tenq;

  assign prod = {{(drs_pkg::KEY_W){1'b0}}, x} *
                {{(drs_pkg::KEY_W){1'b0}}, drs_pkg::DIV_RECIP};
  assign q = drs_pkg::KEY_W'(prod >> drs_pkg::DIV_SHIFT);
  assign tenq_wide = {q, 3'b000} + {2'b00, q, 1'b0};
  assign tenq = tenq_wide[drs_pkg::KEY_W-1:0];
  assign digit = drs_pkg::DIGIT_W'(x - tenq);

endmodule

FILE: src/drs_hist.sv
// Ten-bin digit histogram: count, running sum and slot hand-out for the scatter.
// Depends on drs_pkg.
module drs_hist (
  input  logic                        clk,
  input  logic                        rst,
  input  drs_pkg::hist_ctrl_t         ctrl,
  output logic [drs_pkg::ADDR_W-1:0]  slot
);

  logic [drs_pkg::CNT_W-1:0] counts [drs_pkg::RADIX];
  logic [drs_pkg::CNT_W-1:0] acc;
  logic [drs_pkg::CNT_W-1:0] sum_next;
  logic [drs_pkg::CNT_W-1:0] sel_count;

  assign sel_count = counts[ctrl.digit];
  assign slot      = drs_pkg::ADDR_W'(sel_count - 1'b1);
  assign sum_next  = acc + counts[ctrl.pidx];

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int i = 0; i < drs_pkg::RADIX; i++) begin
        counts[i] <= '0;
      end
      acc <= '0;
    end else if (ctrl.inc) begin
      counts[ctrl.digit] <= sel_count + 1'b1;
    end else if (ctrl.dec) begin
      counts[ctrl.digit] <= sel_count - 1'b1;
    end else if (ctrl.prefix) begin
      counts[ctrl.pidx] <= sum_next;
      acc <= sum_next;
    end
  end

endmodule

FILE: src/decimal_radix_sorter.sv
// Decimal radix sorter top level: sequencer, ping-pong key memory, shared units.
// Depends on drs_pkg, drs_div10, drs_hist and decimal_radix_sorter_defines.svh.
//
// Keys are taken one per cycle while busy is low; keys beyond 64 are dropped
// and overflow is set on every result of that set. After the key marked last,
// busy stays high for the whole sort and output. With N stored keys, the
// sort makes one pass per decimal digit of the largest key; in each pass one
// memory read port sweeps the keys twice, the ten-bin running sum is built
// bin by bin, and one divide-by-ten unit serves every step. The N results
// then leave on consecutive cycles, one per strobe, and busy falls in the
// cycle after the last one. Results cannot be held off by the receiver.
`include "decimal_radix_sorter_defines.svh"

module decimal_radix_sorter (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  drs_pkg::in_beat_t  item,
  output logic               busy,
  output logic               strobe,
  output drs_pkg::out_beat_t result
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_HIST     = 4'd2;
  localparam logic [3:0] S_HIST_END = 4'd3;
  localparam logic [3:0] S_PREFIX   = 4'd4;
  localparam logic [3:0] S_SCAT     = 4'd5;
  localparam logic [3:0] S_SCAT_END = 4'd6;
  localparam logic [3:0] S_NEXT     = 4'd7;
  localparam logic [3:0] S_OUT      = 4'd8;
  localparam logic [3:0] S_OUT_END  = 4'd9;

  logic [3:0]                  state;
  logic                        src;
  logic [drs_pkg::CNT_W-1:0]   count;
  logic [drs_pkg::KEY_W-1:0]   largest_quot;
  logic                        dropped;
  logic [drs_pkg::ADDR_W-1:0]  idx;
  logic                        rd_hist;
  logic                        rd_scat;
  logic                        rd_out;
  logic                        rd_last;
  drs_pkg::entry_t             rdata;

  drs_pkg::entry_t             mem [2*drs_pkg::DEPTH];

  logic                        accept;
  logic                        room;
  logic                        rd_en;
  logic                        last_issue;
  logic [drs_pkg::ADDR_W-1:0]  last_addr;
  logic                        mem_we;
  logic [drs_pkg::ADDR_W:0]    mem_waddr;
  drs_pkg::entry_t             mem_wdata;
  logic [drs_pkg::KEY_W-1:0]   div_x;
  logic [drs_pkg::KEY_W-1:0]   div_q;
  logic [drs_pkg::DIGIT_W-1:0] div_digit;
  logic [drs_pkg::ADDR_W-1:0]  slot;
  drs_pkg::hist_ctrl_t         hctrl;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign room      = (count < drs_pkg::CNT_W'(drs_pkg::DEPTH));
  assign last_addr = drs_pkg::ADDR_W'(count - 1'b1);
  assign rd_en     = (state == S_HIST) || (state == S_SCAT) || (state == S_OUT);

  always_comb begin
    if (state == S_SCAT) begin
      last_issue = (idx == '0);
    end else begin
      last_issue = (idx == last_addr);
    end
  end

  assign div_x = (state == S_NEXT) ? largest_quot : rdata.quot;

  drs_div10 u_div10 (
    .x     (div_x),
    .q     (div_q),
    .digit (div_digit)
  );

  assign hctrl.clear  = (state == S_CHECK);
  assign hctrl.inc    = rd_hist;
  assign hctrl.dec    = rd_scat;
  assign hctrl.prefix = (state == S_PREFIX);
  assign hctrl.digit  = div_digit;
  assign hctrl.pidx   = idx[drs_pkg::DIGIT_W-1:0];

  drs_hist u_hist (
    .clk  (clk),
    .rst  (rst),
    .ctrl (hctrl),
    .slot (slot)
  );

  // Scatter writes the other bank; loading writes the current one
  assign mem_we = (accept && room) || rd_scat;

  always_comb begin
    if (rd_scat) begin
      mem_waddr      = {!src, slot};
      mem_wdata.key  = rdata.key;
      mem_wdata.quot = div_q;
    end else begin
      mem_waddr      = {src, count[drs_pkg::ADDR_W-1:0]};
      mem_wdata.key  = item.key;
      mem_wdata.quot = item.key;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= mem[{src, idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      src          <= 1'b0;
      count        <= '0;
      largest_quot <= '0;
      dropped      <= 1'b0;
      idx          <= '0;
      rd_hist      <= 1'b0;
      rd_scat      <= 1'b0;
      rd_out       <= 1'b0;
      rd_last      <= 1'b0;
    end else begin
      rd_hist <= (state == S_HIST);
      rd_scat <= (state == S_SCAT);
      rd_out  <= (state == S_OUT);
      rd_last <= (state == S_OUT) && last_issue;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (room) begin
              count <= count + 1'b1;
              if (item.key > largest_quot) begin
                largest_quot <= item.key;
              end
            end else begin
              dropped <= 1'b1;
            end
            if (item.last_in) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          idx <= '0;
          if (largest_quot == '0) begin
            state <= S_OUT;
          end else begin
            state <= S_HIST;
          end
        end
        S_HIST: begin
          if (last_issue) begin
            state <= S_HIST_END;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_HIST_END: begin
          idx   <= '0;
          state <= S_PREFIX;
        end
        S_PREFIX: begin
          if (idx == drs_pkg::ADDR_W'(drs_pkg::RADIX - 1)) begin
            idx   <= last_addr;
            state <= S_SCAT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SCAT: begin
          if (last_issue) begin
            state <= S_SCAT_END;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_SCAT_END: begin
          state <= S_NEXT;
        end
        S_NEXT: begin
          largest_quot <= div_q;
          src          <= !src;
          state        <= S_CHECK;
        end
        S_OUT: begin
          if (last_issue) begin
            state <= S_OUT_END;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_OUT_END: begin
          count        <= '0;
          largest_quot <= '0;
          dropped      <= 1'b0;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign strobe            = rd_out;
  assign result.sorted_key = rdata.key;
  assign result.last_out   = rd_last;
  assign result.overflow   = dropped;

  `DRS_ASSERT_NOW(a_beat_only_busy, strobe, busy)
  `DRS_ASSERT_NEXT(a_idle_after_last, strobe && result.last_out, !busy)
  `DRS_ASSERT_NOW(a_busy_from_start, $rose(busy), $past(start) && $past(item.last_in))
  `DRS_ASSERT_NOW(a_slot_in_set, rd_scat, {1'b0, slot} < count)

endmodule

FILE: test/drs_order_monitor.sv
// Order monitor for the decimal radix sorter: predicts each sorted set and checks result beats.
// Depends on drs_pkg for the beat types and sizes.
`timescale 1ns / 1ps

module drs_order_monitor
  import drs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  in_beat_t  item,
  input  logic      strobe,
  input  out_beat_t result,
  output int        errors,
  output int        pending
);

  out_beat_t        sorted_due [$];
  logic [KEY_W-1:0] held_keys [DEPTH];
  logic [KEY_W-1:0] scatter_keys [DEPTH];
  int unsigned      held_count = 0;
  int unsigned      peak_key = 0;
  bit               keys_dropped = 0;
  int               fault_count = 0;

  // one stable counting pass per decimal digit of the peak key
  function automatic void radix_sort_held();
    int unsigned place;
    int unsigned digit;
    int unsigned i;
    int unsigned tally [RADIX];
    place = 1;
    while (peak_key / place > 0) begin
      for (digit = 0; digit < RADIX; digit++) tally[digit] = 0;
      for (i = 0; i < held_count; i++) tally[(held_keys[i] / place) % RADIX]++;
      for (digit = 1; digit < RADIX; digit++) tally[digit] += tally[digit - 1];
      for (i = held_count; i > 0; i--) begin
        digit = (held_keys[i - 1] / place) % RADIX;
        tally[digit]--;
        scatter_keys[tally[digit]] = held_keys[i - 1];
      end
      for (i = 0; i < held_count; i++) held_keys[i] = scatter_keys[i];
      place *= RADIX;
    end
  endfunction

  function automatic void take_key(input in_beat_t b);
    out_beat_t   r;
    int unsigned j;
    if (held_count < DEPTH) begin
      held_keys[held_count] = b.key;
      held_count++;
      if (b.key > peak_key) peak_key = b.key;
    end else begin
      keys_dropped = 1'b1;
    end
    if (b.last_in) begin
      radix_sort_held();
      for (j = 0; j < held_count; j++) begin
        r.sorted_key = held_keys[j];
        r.last_out   = (j + 1 == held_count);
        r.overflow   = keys_dropped;
        sorted_due.push_back(r);
      end
      held_count   = 0;
      peak_key     = 0;
      keys_dropped = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      held_count   = 0;
      peak_key     = 0;
      keys_dropped = 1'b0;
      sorted_due.delete();
    end else begin
      if (strobe) begin
        if (sorted_due.size() == 0) begin
          $error("result beat with nothing expected: sorted_key %0d", result.sorted_key);
          fault_count++;
        end else begin
          want = sorted_due.pop_front();
          if (result.sorted_key !== want.sorted_key) begin
            $error("sorted_key: expected %0d, actual %0d", want.sorted_key, result.sorted_key);
            fault_count++;
          end
          if (result.last_out !== want.last_out) begin
            $error("last_out: expected %0b, actual %0b", want.last_out, result.last_out);
            fault_count++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, result.overflow);
            fault_count++;
          end
        end
      end
      if (start && !busy) take_key(item);
    end
    errors  <= fault_count;
    pending <= sorted_due.size();
  end

endmodule

FILE: test/decimal_radix_sorter_tb.sv
// Testbench top for the decimal radix sorter: drives key sets, watches for stalls, gives the verdict.
// Depends on drs_pkg, decimal_radix_sorter and drs_order_monitor.
`timescale 1ns / 1ps

module decimal_radix_sorter_tb;
  import drs_pkg::*;

  localparam int QUIET_LIMIT = 10000;

  logic      clk;
  logic      rst;
  logic      start;
  in_beat_t  item;
  logic      busy;
  logic      strobe;
  out_beat_t result;
  int        errors;
  int        pending;
  int        quiet_cycles = 0;
  int        fed_keys = 0;

  logic [KEY_W-1:0] set_keys [$];

  decimal_radix_sorter uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  drs_order_monitor order_mon (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .strobe  (strobe),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [KEY_W-1:0] random_key();
    int unsigned span;
    if ($urandom_range(0, 3) == 0) begin
      return KEY_W'($urandom_range(0, 1048575));
    end
    span = 10 ** $urandom_range(1, 7);
    if (span > 1048576) span = 1048576;
    return KEY_W'($urandom_range(0, span - 1));
  endfunction

  task automatic idle_for(input int unsigned n);
    in_beat_t noise;
    repeat (n) begin
      noise.key     = KEY_W'($urandom);
      noise.last_in = 1'($urandom);
      @(negedge clk);
      start <= 1'b0;
      item  <= noise;
    end
  endtask

  task automatic send_key(input logic [KEY_W-1:0] k, input logic lst);
    in_beat_t b;
    b.key     = k;
    b.last_in = lst;
    @(negedge clk);
    start <= 1'b1;
    item  <= b;
    do @(posedge clk); while (busy);
  endtask

  // hand over one beat per queued key, marking the final one
  task automatic feed_set(input bit gaps);
    int n;
    for (n = 0; n < set_keys.size(); n++) begin
      if (gaps && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 8));
      send_key(set_keys[n], n == set_keys.size() - 1);
      fed_keys++;
    end
    set_keys.delete();
  endtask

  initial begin
    int set_no;
    int size;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_keys = '{20'd1048575};
    feed_set(1'b0);
    set_keys = '{20'd0, 20'd0, 20'd0};
    feed_set(1'b1);
    set_keys = '{20'd5, 20'd3, 20'd5, 20'd0, 20'd1048575, 20'd10, 20'd9, 20'd100000, 20'd3};
    feed_set(1'b1);
    set_keys = '{20'd999999, 20'd1000000, 20'd524288, 20'd1, 20'd7, 20'd7};
    feed_set(1'b0);

    set_no = 0;
    while (fed_keys < 100) begin
      case (set_no)
        2: size = $urandom_range(DEPTH + 1, DEPTH + 3);
        default: size = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 40)
                                                     : $urandom_range(1, 10);
      endcase
      repeat (size) set_keys.push_back(random_key());
      feed_set(fed_keys < 75 && $urandom_range(0, 1) == 1);
      set_no++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
